>>> rtl/core/rsa_exponent_derivation_defines.svh
// assertion macros for the rsa exponent derivation block
`ifndef RSA_EXPONENT_DERIVATION_DEFINES_SVH
`define RSA_EXPONENT_DERIVATION_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RSAED_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked at the next clock edge
`define RSAED_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/rsaed_pkg.sv
// shared types and constants for the rsa exponent derivation block
`timescale 1ns / 1ps
package rsaed_pkg;
	localparam int unsigned PRIME_BITS_DEF = 32;
	localparam logic [31:0] START_RESET = 32'd10000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_N,
		S_MUL_T,
		S_CHECK,
		S_GCD,
		S_GCD_WAIT,
		S_INV,
		S_INV_WAIT,
		S_FIN1,
		S_FIN2,
		S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;
endpackage

>>> rtl/core/rsaed_div.sv
// shared restoring divider, one quotient bit per cycle, with quotient times multiplier
`timescale 1ns / 1ps
module rsaed_div import rsaed_pkg::*; #(
	parameter int unsigned W = 2 * PRIME_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	input  logic [W-1:0] mult,
	output logic [W-1:0] remainder,
	output logic [W-1:0] product,
	output div_stat_t    stat
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  dvs_q;
	logic [W-1:0]  mul_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic          qbit;
	logic [W:0]    diff;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign qbit    = (shifted >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			acc_q <= '0;
			dvs_q <= divisor;
			mul_q <= mult;
		end else if (busy_q) begin
			rem_q <= qbit ? diff : shifted;
			quo_q <= {quo_q[W-2:0], qbit};
			acc_q <= {acc_q[W-2:0], 1'b0} + (qbit ? mul_q : '0);
		end
	end

	assign remainder = rem_q[W-1:0];
	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

>>> rtl/core/rsa_exponent_derivation.sv
// top level: rsa modulus, public exponent search and private exponent
`timescale 1ns / 1ps
// usage
//   start/busy: a factor pair (prime_p, prime_q) transfers at a clock edge with
//   start high and busy low; only the low PRIME_BITS bits of each factor are used
//   result: modulus, public_exponent, private_exponent and status appear for one
//   cycle with result_valid high; the receiver cannot stall and must take it then
//   apb: exponent_start at byte address 0, written in the access phase, pready tied high
// latency
//   two multiplier cycles, then per candidate exponent one gcd made of divisions,
//   then one extended euclid made of divisions, then three cycles to finish
//   every division runs on one shared restoring divider: 2*PRIME_BITS + 2 cycles each
//   total is data dependent, on the order of a few thousand cycles per key
// throughput
//   one key at a time; busy stays high from the transfer until the result strobe
// reset
//   arst_n clears the sequencer and loads exponent_start with 10000
// status
//   1 when no coprime exponent lies below the totient; both exponents are then zero
module rsa_exponent_derivation import rsaed_pkg::*; #(
	parameter int unsigned PRIME_BITS = PRIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] prime_p,
	input  logic [31:0] prime_q,
	output logic        result_valid,
	output logic [63:0] modulus,
	output logic [63:0] public_exponent,
	output logic [63:0] private_exponent,
	output logic        status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
`include "rsa_exponent_derivation_defines.svh"

	localparam int unsigned W  = 2 * PRIME_BITS;
	localparam int unsigned EW = (W > 32) ? W : 32;

	state_t state_q, state_d;

	// configuration
	logic [31:0] start_q;
	logic        cfg_wr;

	// operands and working values
	logic [PRIME_BITS-1:0] p_q, q_q;
	logic [PRIME_BITS-1:0] pm, qm, mul_a, mul_b;
	logic [W-1:0]          prod;
	logic [W-1:0]          n_q, t_q;
	logic [EW-1:0]         e_q;
	logic [W-1:0]          a_q, b_q, m0_q, m1_q, d_q;
	logic                  k_q;
	logic                  e_lt_t;
	logic [W-1:0]          m0_red;

	// divider hookup
	logic                  div_start;
	logic [W-1:0]          div_rem, div_prod;
	div_stat_t             div_stat;

	// result registers
	logic                  valid_q;
	logic [63:0]           mod_q, pub_q, priv_q;
	logic                  status_q;
	logic                  found;

	// apb: a single register, pready tied high
	assign pready = 1'b1;
	assign prdata = start_q;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
		end else if (cfg_wr) begin
			start_q <= pwdata;
		end
	end

	// factor minus one saturates at zero
	assign pm = (p_q == '0) ? '0 : p_q - 1'b1;
	assign qm = (q_q == '0) ? '0 : q_q - 1'b1;

	// one shared multiplier: modulus first, then totient
	assign mul_a = (state_q == S_MUL_N) ? p_q : pm;
	assign mul_b = (state_q == S_MUL_N) ? q_q : qm;
	assign prod  = {{PRIME_BITS{1'b0}}, mul_a} * {{PRIME_BITS{1'b0}}, mul_b};

	assign e_lt_t = (e_q < EW'(t_q));
	assign m0_red = (m0_q >= t_q) ? m0_q - t_q : m0_q;
	assign found  = (state_q == S_DONE) && e_lt_t;

	rsaed_div #(.W(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (a_q),
		.divisor   (b_q),
		.mult      (m1_q),
		.remainder (div_rem),
		.product   (div_prod),
		.stat      (div_stat)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and divider kick
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_MUL_N;
			end
			S_MUL_N: state_d = S_MUL_T;
			S_MUL_T: state_d = S_CHECK;
			S_CHECK: begin
				state_d = e_lt_t ? S_GCD : S_DONE;
			end
			S_GCD: begin
				if (b_q == '0) begin
					state_d = (a_q == W'(1)) ? S_INV : S_CHECK;
				end else begin
					div_start = 1'b1;
					state_d   = S_GCD_WAIT;
				end
			end
			S_GCD_WAIT: begin
				if (div_stat.done) state_d = S_GCD;
			end
			S_INV: begin
				if (b_q == '0) begin
					state_d = S_FIN1;
				end else begin
					div_start = 1'b1;
					state_d   = S_INV_WAIT;
				end
			end
			S_INV_WAIT: begin
				if (div_stat.done) state_d = S_INV;
			end
			S_FIN1: state_d = S_FIN2;
			S_FIN2: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					p_q <= prime_p[PRIME_BITS-1:0];
					q_q <= prime_q[PRIME_BITS-1:0];
					e_q <= EW'(start_q);
				end
			end
			S_MUL_N: n_q <= prod;
			S_MUL_T: t_q <= prod;
			S_CHECK: begin
				// gcd(e, t) with e below t starts at (t, e)
				a_q <= t_q;
				b_q <= W'(e_q);
			end
			S_GCD: begin
				if (b_q == '0) begin
					if (a_q == W'(1)) begin
						a_q  <= t_q;
						b_q  <= W'(e_q);
						m0_q <= '0;
						m1_q <= W'(1);
						k_q  <= 1'b0;
					end else begin
						e_q <= e_q + 1'b1;
					end
				end
			end
			S_GCD_WAIT: begin
				if (div_stat.done) begin
					a_q <= b_q;
					b_q <= div_rem;
				end
			end
			S_INV_WAIT: begin
				if (div_stat.done) begin
					a_q  <= b_q;
					b_q  <= div_rem;
					m0_q <= m1_q;
					m1_q <= m0_q + div_prod;
					k_q  <= ~k_q;
				end
			end
			S_FIN1: begin
				// coefficient sign follows the step parity
				if (m0_q == '0) d_q <= '0;
				else if (k_q)   d_q <= m0_q;
				else            d_q <= t_q - m0_red;
			end
			S_FIN2: begin
				if (d_q >= t_q) d_q <= d_q - t_q;
			end
			S_DONE: begin
				mod_q    <= 64'(n_q);
				pub_q    <= found ? 64'(e_q) : '0;
				priv_q   <= found ? 64'(d_q) : '0;
				status_q <= ~found;
			end
			default: begin
			end
		endcase
	end

	// one-cycle result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= (state_q == S_DONE);
		end
	end

	assign busy             = (state_q != S_IDLE);
	assign result_valid     = valid_q;
	assign modulus          = mod_q;
	assign public_exponent  = pub_q;
	assign private_exponent = priv_q;
	assign status           = status_q;

	// a transfer always moves the sequencer out of idle
	`RSAED_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted key did not raise busy")
	// the divider is only kicked while idle
	`RSAED_ASSERT_IMP(a_div_free, div_start, !div_stat.busy, "divider started while running")
	// a failed search never reports exponents
	`RSAED_ASSERT_IMP(a_fail_zero, result_valid && status,
		public_exponent == '0 && private_exponent == '0, "nonzero exponent with error status")
endmodule

>>> test/tb_top.sv
// testbench for rsa_exponent_derivation: directed table, then random keys against a predictor
`timescale 1ns / 1ps
module tb_top;
	import rsaed_pkg::*;

	// register byte address of exponent_start
	localparam logic [1:0] ADDR_EXPONENT_START = 2'd0;
	localparam logic [63:0] FACTOR_MASK = (64'd1 << PRIME_BITS_DEF) - 64'd1;
	localparam int RANDOM_KEYS = 275;

	typedef struct {
		logic [63:0] modulus;
		logic [63:0] public_exponent;
		logic [63:0] private_exponent;
		logic        status;
	} key_t;

	// one row of the directed table
	typedef struct {
		logic [31:0] exp_start;
		logic [31:0] p;
		logic [31:0] q;
		bit          typed;
		key_t        key;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] prime_p;
	logic [31:0] prime_q;
	logic        result_valid;
	logic [63:0] modulus;
	logic [63:0] public_exponent;
	logic [63:0] private_exponent;
	logic        status;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// predictor copy of the exponent_start register
	logic [31:0] start_model;
	key_t        pending_keys[$];
	int          errors = 0;
	int          keys_checked = 0;
	int          invalid_keys = 0;
	int          idle_pct = 0;

	rsa_exponent_derivation dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.prime_p(prime_p),
		.prime_q(prime_q),
		.result_valid(result_valid),
		.modulus(modulus),
		.public_exponent(public_exponent),
		.private_exponent(private_exponent),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// euclid gcd on 64-bit magnitudes
	function automatic logic [63:0] gcd_u64(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		while (b != 64'd0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	// extended euclid, coefficients tracked as magnitudes with alternating sign
	function automatic logic [63:0] exp_inverse(logic [63:0] e, logic [63:0] t);
		logic [63:0] r0, r1, r2, m0, m1, m2, qt, d;
		bit          odd_steps;
		r0 = t;
		r1 = e % t;
		m0 = 64'd0;
		m1 = 64'd1;
		odd_steps = 1'b0;
		while (r1 != 64'd0) begin
			qt = r0 / r1;
			r2 = r0 - qt * r1;
			m2 = m0 + qt * m1;
			r0 = r1;
			r1 = r2;
			m0 = m1;
			m1 = m2;
			odd_steps = ~odd_steps;
		end
		if (m0 == 64'd0)
			return 64'd0;
		// sign of the coefficient flips with every division step
		d = odd_steps ? m0 : t - (m0 % t);
		if (d >= t)
			d -= t;
		return d;
	endfunction

	// modulus, exponent search and private exponent for one factor pair
	function automatic key_t derive_key(logic [31:0] p_in, logic [31:0] q_in,
		logic [31:0] exp_start);
		key_t        k;
		logic [63:0] p, q, pm, qm, t, e;
		bit          found;
		p = {32'd0, p_in} & FACTOR_MASK;
		q = {32'd0, q_in} & FACTOR_MASK;
		// factor zero saturates the minus-one term
		pm = (p != 64'd0) ? p - 64'd1 : 64'd0;
		qm = (q != 64'd0) ? q - 64'd1 : 64'd0;
		t = pm * qm;
		e = {32'd0, exp_start};
		found = 1'b0;
		while (e < t && !found) begin
			if (gcd_u64(e, t) == 64'd1)
				found = 1'b1;
			else
				e++;
		end
		k.modulus = p * q;
		k.public_exponent = found ? e : 64'd0;
		k.private_exponent = found ? exp_inverse(e, t) : 64'd0;
		k.status = !found;
		return k;
	endfunction

	// result checker, sampled at the edge that ends the strobe cycle
	always @(posedge clk) begin
		key_t want;
		if (arst_n && result_valid) begin
			if (pending_keys.size() == 0) begin
				$display("%0t: unexpected result transfer modulus=%h", $time, modulus);
				errors++;
			end else begin
				want = pending_keys.pop_front();
				keys_checked++;
				if (want.status)
					invalid_keys++;
				if (modulus !== want.modulus) begin
					$display("%0t: modulus expected %h actual %h", $time,
						want.modulus, modulus);
					errors++;
				end
				if (public_exponent !== want.public_exponent) begin
					$display("%0t: public_exponent expected %h actual %h", $time,
						want.public_exponent, public_exponent);
					errors++;
				end
				if (private_exponent !== want.private_exponent) begin
					$display("%0t: private_exponent expected %h actual %h", $time,
						want.private_exponent, private_exponent);
					errors++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %b actual %b", $time,
						want.status, status);
					errors++;
				end
			end
		end
	end

	// stop offering keys, wait until every key has come back, then let the sequencer settle
	task automatic drain();
		start <= 1'b0;
		while (pending_keys.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// apb write of exponent_start followed by a read back
	task automatic write_exp_start(logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_EXPONENT_START;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		start_model = value;
		// read setup follows straight on, psel stays high
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== value) begin
			$display("%0t: exponent_start read expected %h actual %h", $time, value, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// change the start exponent only with the block idle
	task automatic set_exp_start(logic [31:0] value);
		if (value != start_model) begin
			drain();
			write_exp_start(value);
		end
	endtask

	// offer one factor pair and hold it until busy is low at a clock edge
	task automatic send_key(logic [31:0] p, logic [31:0] q, output key_t want);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		prime_p <= p;
		prime_q <= q;
		do
			@(posedge clk);
		while (busy);
		want = derive_key(p, q, start_model);
		pending_keys.push_back(want);
	endtask

	// factor mostly small to keep key generation short, sometimes full width
	function automatic logic [31:0] pick_factor();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 4)
			return $urandom_range(1);
		if (sel < 80)
			return $urandom_range(4095, 2);
		if (sel < 93)
			return $urandom_range(1048575, 2);
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_exp_start();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 50)
			return $urandom_range(60, 3);
		if (sel < 65)
			return START_RESET;
		if (sel < 80)
			return $urandom_range(1000000, 3);
		if (sel < 90)
			return 32'hFFFF_FFFF;
		return $urandom_range(32'hFFFF_FFFF, 3);
	endfunction

	row_t directed[$];

	initial begin
		key_t want;
		int   phase_len;
		arst_n = 1'b0;
		start = 1'b0;
		prime_p = 32'd0;
		prime_q = 32'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 2'd0;
		pwdata = 32'd0;
		start_model = START_RESET;

		// start exponent, p, q, typed expectation
		directed = '{
			// reset start: every small totient lies below it
			'{START_RESET, 32'd0, 32'd5, 1'b1, '{64'd0, 64'd0, 64'd0, 1'b1}},
			'{START_RESET, 32'd1, 32'd7, 1'b1, '{64'd7, 64'd0, 64'd0, 1'b1}},
			'{START_RESET, 32'd2, 32'd2, 1'b1, '{64'd4, 64'd0, 64'd0, 1'b1}},
			'{START_RESET, 32'd61, 32'd53, 1'b1, '{64'd3233, 64'd0, 64'd0, 1'b1}},
			'{START_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
				'{64'd0, 64'd0, 64'd0, 1'b0}},
			'{START_RESET, 32'hFFFF_FFFF, 32'd0, 1'b1, '{64'd0, 64'd0, 64'd0, 1'b1}},
			'{START_RESET, 32'd2, 32'hFFFF_FFFF, 1'b0, '{64'd0, 64'd0, 64'd0, 1'b0}},
			// textbook key
			'{32'd17, 32'd61, 32'd53, 1'b1, '{64'd3233, 64'd17, 64'd2753, 1'b0}},
			'{32'd17, 32'd2, 32'd3, 1'b1, '{64'd6, 64'd0, 64'd0, 1'b1}},
			// lowest start exponent
			'{32'd3, 32'd3, 32'd5, 1'b1, '{64'd15, 64'd3, 64'd3, 1'b0}},
			'{32'd3, 32'd3, 32'd3, 1'b1, '{64'd9, 64'd3, 64'd3, 1'b0}},
			'{32'd3, 32'd5, 32'd7, 1'b1, '{64'd35, 64'd5, 64'd5, 1'b0}},
			'{32'd3, 32'd2, 32'd3, 1'b1, '{64'd6, 64'd0, 64'd0, 1'b1}},
			'{32'd3, 32'h8000_0000, 32'h8000_0001, 1'b0, '{64'd0, 64'd0, 64'd0, 1'b0}},
			'{32'd3, 32'd65537, 32'd65539, 1'b0, '{64'd0, 64'd0, 64'd0, 1'b0}},
			// highest start exponent
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0,
				'{64'd0, 64'd0, 64'd0, 1'b0}},
			'{32'hFFFF_FFFF, 32'd65537, 32'd65539, 1'b0, '{64'd0, 64'd0, 64'd0, 1'b0}},
			'{32'hFFFF_FFFF, 32'd3, 32'd5, 1'b1, '{64'd15, 64'd0, 64'd0, 1'b1}}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed rows override the predictor
		idle_pct = 29;
		foreach (directed[i]) begin
			set_exp_start(directed[i].exp_start);
			send_key(directed[i].p, directed[i].q, want);
			if (directed[i].typed) begin
				void'(pending_keys.pop_back());
				pending_keys.push_back(directed[i].key);
			end
		end

		// random keys in phases, each with its own start exponent
		phase_len = 0;
		for (int n = 0; n < RANDOM_KEYS; n++) begin
			if (n < RANDOM_KEYS / 3)
				idle_pct = 29;
			else if (n < 2 * RANDOM_KEYS / 3)
				idle_pct = 79;
			else
				idle_pct = 0;
			if (phase_len == 0) begin
				set_exp_start(pick_exp_start());
				phase_len = $urandom_range(40, 10);
			end
			phase_len--;
			send_key(pick_factor(), pick_factor(), want);
		end

		drain();
		repeat (20) @(posedge clk);
		$display("checked %0d keys, %0d of them with no coprime exponent,", keys_checked,
			invalid_keys);
		$display("start exponents from 3 to the 32-bit maximum, factors up to 32 bits");
		if (errors == 0)
			$display("rsa_exponent_derivation: match");
		else
			$display("rsa_exponent_derivation: mismatch");
		$finish;
	end

	// run limit
	initial begin
		#(64'd900_000_000);
		$display("rsa_exponent_derivation: mismatch");
		$finish;
	end
endmodule
